// ===== design/lbod_pkg.sv =====
// types and constants shared by the led blink override driver
`timescale 1ns / 1ps

package lbod_pkg;

  localparam int unsigned OVERRIDE_LIMIT_MS = 30000;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned OVR_REM_W = $clog2(OVERRIDE_LIMIT_MS);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0] OVERRIDE_LIMIT = TIME_W'(OVERRIDE_LIMIT_MS);

  typedef enum logic [0:0] {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } item_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_RED      = 3'd0,
    REG_COLOR_GREEN    = 3'd1,
    REG_COLOR_BLUE     = 3'd2,
    REG_BLINK_MODE     = 3'd3,
    REG_BLINK_ON_TIME  = 3'd4,
    REG_BLINK_OFF_TIME = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [0:0]         mode;
    logic [TIME_W-1:0]  tick_ms;
    logic [COLOR_W-1:0] override_red;
    logic [COLOR_W-1:0] override_green;
    logic [COLOR_W-1:0] override_blue;
    logic [TIME_W-1:0]  override_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] drive_red;
    logic [COLOR_W-1:0] drive_green;
    logic [COLOR_W-1:0] drive_blue;
    logic [0:0]         drive_valid;
    logic [0:0]         accepted;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

endpackage

// ===== design/lbod_ifs.sv =====
// handshake channel interfaces for items, results and register writes
`timescale 1ns / 1ps

interface lbod_in_if;
  import lbod_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbod_out_if;
  import lbod_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbod_cfg_if;
  import lbod_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/led_blink_override_driver_unit.sv =====
// top level: one rgb led channel with steady or blinking color and timed override
//
// channels: in_if takes tick items (elapsed ms) and override loads; out_if
// returns one result per item; cfg_if writes the color and blink registers.
// an item is registered on transfer, evaluated against the channel state and
// placed in the result register once that register is empty or its result
// is being taken; the result register then holds it until it is taken.
// one item per cycle is sustained while the receiver takes every result: the
// input register refills in the same cycle that its item moves on.
// loads answer accepted = 0 when the time is 30000 ms or more and then leave
// the state untouched; loads always return black with drive_valid low.
// reset clears registers, override and blink state; the led reads dark.
// when the receiver stalls, the result register holds and the input
// register still takes one more item, then in_if.ready drops until the
// result is taken. register writes are always ready and expected while idle.
`timescale 1ns / 1ps

module led_blink_override_driver_unit (
  input  logic clk,
  input  logic rst_n,
  lbod_in_if.sink    in_if,
  lbod_out_if.source out_if,
  lbod_cfg_if.sink   cfg_if
);
  import lbod_pkg::*;

  // configuration
  rgb_t              color_r;
  logic              blink_mode_r;
  logic [TIME_W-1:0] blink_on_r;
  logic [TIME_W-1:0] blink_off_r;

  // channel state
  logic                 ovr_act_r, ovr_act_nxt;
  logic [OVR_REM_W-1:0] ovr_rem_r, ovr_rem_nxt;
  rgb_t                 ovr_rgb_r, ovr_rgb_nxt;
  logic [TIME_W-1:0]    blink_rem_r, blink_rem_nxt;
  logic                 blink_lit_r, blink_lit_nxt;

  // pipeline
  logic      in_v_r;
  in_item_t  in_r;
  logic      out_v_r;
  out_item_t out_r, out_nxt;
  logic      move;

  logic                 is_load;
  logic                 refuse;
  logic [TIME_W-1:0]    ovr_rem_ext;
  logic                 blink_lit_tmp;

  assign move        = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || move;
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;
  assign cfg_if.ready = 1'b1;

  assign is_load     = (in_r.mode == MODE_LOAD);
  assign refuse      = (in_r.override_time_ms >= OVERRIDE_LIMIT);
  assign ovr_rem_ext = TIME_W'(ovr_rem_r);

  always_comb begin
    ovr_act_nxt   = ovr_act_r;
    ovr_rem_nxt   = ovr_rem_r;
    ovr_rgb_nxt   = ovr_rgb_r;
    blink_rem_nxt = blink_rem_r;
    blink_lit_nxt = blink_lit_r;
    blink_lit_tmp = blink_lit_r;
    out_nxt       = '0;
    if (is_load) begin
      if (!refuse) begin
        ovr_act_nxt      = 1'b1;
        ovr_rem_nxt      = in_r.override_time_ms[OVR_REM_W-1:0];
        ovr_rgb_nxt      = '{in_r.override_red, in_r.override_green, in_r.override_blue};
        out_nxt.accepted = 1'b1;
      end
    end else begin
      out_nxt.drive_valid = 1'b1;
      out_nxt.accepted    = 1'b1;
      if (ovr_act_r) begin
        out_nxt.drive_red   = ovr_rgb_r.red;
        out_nxt.drive_green = ovr_rgb_r.green;
        out_nxt.drive_blue  = ovr_rgb_r.blue;
        if (in_r.tick_ms >= ovr_rem_ext) begin
          ovr_act_nxt = 1'b0;
          ovr_rem_nxt = '0;
        end else begin
          ovr_rem_nxt = OVR_REM_W'(ovr_rem_ext - in_r.tick_ms);
        end
      end else if (!blink_mode_r) begin
        out_nxt.drive_red   = color_r.red;
        out_nxt.drive_green = color_r.green;
        out_nxt.drive_blue  = color_r.blue;
      end else begin
        if (in_r.tick_ms >= blink_rem_r) begin
          blink_lit_tmp = !blink_lit_r;
          blink_rem_nxt = blink_lit_tmp ? blink_on_r : blink_off_r;
        end else begin
          blink_rem_nxt = blink_rem_r - in_r.tick_ms;
        end
        blink_lit_nxt = blink_lit_tmp;
        if (blink_lit_tmp) begin
          out_nxt.drive_red   = color_r.red;
          out_nxt.drive_green = color_r.green;
          out_nxt.drive_blue  = color_r.blue;
        end
      end
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r      <= '0;
      blink_mode_r <= 1'b0;
      blink_on_r   <= '0;
      blink_off_r  <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_COLOR_RED:      color_r.red   <= cfg_if.wdata[COLOR_W-1:0];
        REG_COLOR_GREEN:    color_r.green <= cfg_if.wdata[COLOR_W-1:0];
        REG_COLOR_BLUE:     color_r.blue  <= cfg_if.wdata[COLOR_W-1:0];
        REG_BLINK_MODE:     blink_mode_r  <= cfg_if.wdata[0];
        REG_BLINK_ON_TIME:  blink_on_r    <= cfg_if.wdata[TIME_W-1:0];
        REG_BLINK_OFF_TIME: blink_off_r   <= cfg_if.wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // channel state, updated as each item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_act_r   <= 1'b0;
      ovr_rem_r   <= '0;
      ovr_rgb_r   <= '0;
      blink_rem_r <= '0;
      blink_lit_r <= 1'b0;
    end else if (move) begin
      ovr_act_r   <= ovr_act_nxt;
      ovr_rem_r   <= ovr_rem_nxt;
      ovr_rgb_r   <= ovr_rgb_nxt;
      blink_rem_r <= blink_rem_nxt;
      blink_lit_r <= blink_lit_nxt;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_v_r <= in_if.valid;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_r <= in_if.data;
    end
    if (move) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ovr_rem_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ovr_rem_r < OVR_REM_W'(OVERRIDE_LIMIT_MS))
    else $error("override countdown beyond limit");

  a_ovr_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !ovr_act_r |-> (ovr_rem_r == '0))
    else $error("override countdown left over after override ended");

  a_load_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.drive_valid) |->
      (out_r.drive_red == '0 && out_r.drive_green == '0 && out_r.drive_blue == '0))
    else $error("load result carries a color");

  a_refuse_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (move && is_load && refuse) |=>
      ($stable(ovr_act_r) && $stable(ovr_rem_r) && $stable(ovr_rgb_r)))
    else $error("refused load changed override state");

  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_if.ready && in_v_r) |-> !in_if.ready)
    else $error("input taken with both stages full and receiver stalled");
`endif

endmodule
